[src/tsq_pkg.sv]
`timescale 1ns / 1ps

package tsq_pkg;

	// default geometry and group size
	localparam int SAMPLES_PER_READ_DEF = 2;
	localparam int SCREEN_WIDTH_DEF     = 480;
	localparam int SCREEN_HEIGHT_DEF    = 320;

	// field widths
	localparam int RAW_W      = 10;
	localparam int PRESS_W    = 12;
	localparam int SCREEN_X_W = 9;
	localparam int SCREEN_Y_W = 9;
	localparam int GAIN_W     = 18;
	localparam int OFFSET_W   = 28;
	localparam int JUMP_W     = 9;
	localparam int FRAC_W     = 14;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_X       = 3'd0,
		REG_OFFSET_X     = 3'd1,
		REG_GAIN_Y       = 3'd2,
		REG_OFFSET_Y     = 3'd3,
		REG_MIN_PRESSURE = 3'd4,
		REG_MAX_PRESSURE = 3'd5,
		REG_MAX_JUMP     = 3'd6
	} cfg_reg_t;

	// register reset values
	localparam logic signed [GAIN_W-1:0]   GAIN_X_RST   = -18'sd9566;
	localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = 28'sd9059348;
	localparam logic signed [GAIN_W-1:0]   GAIN_Y_RST   = -18'sd6885;
	localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = 28'sd6127909;
	localparam logic [PRESS_W-1:0]         MIN_PRESS_RST = 12'd80;
	localparam logic [PRESS_W-1:0]         MAX_PRESS_RST = 12'd1000;
	localparam logic [JUMP_W-1:0]          MAX_JUMP_RST  = 9'd35;

endpackage

[src/tsq_in_if.sv]
`timescale 1ns / 1ps

interface tsq_in_if;
	logic                         valid;
	logic                         ready;
	logic [tsq_pkg::RAW_W-1:0]    raw_x;
	logic [tsq_pkg::RAW_W-1:0]    raw_y;
	logic [tsq_pkg::PRESS_W-1:0]  raw_pressure;

	modport source (output valid, output raw_x, output raw_y, output raw_pressure,
		input ready);
	modport sink (input valid, input raw_x, input raw_y, input raw_pressure,
		output ready);
endinterface

[src/tsq_out_if.sv]
`timescale 1ns / 1ps

interface tsq_out_if;
	logic                           valid;
	logic                           ready;
	logic                           touch_valid;
	logic [tsq_pkg::SCREEN_X_W-1:0] screen_x;
	logic [tsq_pkg::SCREEN_Y_W-1:0] screen_y;

	modport source (output valid, output touch_valid, output screen_x, output screen_y,
		input ready);
	modport sink (input valid, input touch_valid, input screen_x, input screen_y,
		output ready);
endinterface

[src/tsq_map_axis.sv]
`timescale 1ns / 1ps

module tsq_map_axis #(
	parameter int LIMIT   = tsq_pkg::SCREEN_WIDTH_DEF,
	parameter int COORD_W = $clog2(LIMIT)
) (
	input  logic signed [tsq_pkg::GAIN_W-1:0]   gain,
	input  logic signed [tsq_pkg::OFFSET_W-1:0] offset,
	input  logic [tsq_pkg::RAW_W-1:0]           raw,
	output logic [COORD_W-1:0]                  coord
);

	localparam int PROD_W = tsq_pkg::OFFSET_W + 1;
	localparam int Q_W    = PROD_W - tsq_pkg::FRAC_W;

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] v;
	logic [Q_W-1:0]           q;

	// 18 x 11 signed product stays within 28 bits, one more for the offset add
	assign prod = PROD_W'(gain * $signed({1'b0, raw}));
	assign v    = prod + $signed({offset[tsq_pkg::OFFSET_W-1], offset});
	assign q    = v[PROD_W-1:tsq_pkg::FRAC_W];

	always_comb begin
		if (v[PROD_W-1]) begin
			coord = '0;
		end else if (q > Q_W'(LIMIT - 1)) begin
			coord = COORD_W'(LIMIT - 1);
		end else begin
			coord = q[COORD_W-1:0];
		end
	end

endmodule

[src/touch_sample_qualifier_top.sv]
`timescale 1ns / 1ps

// channel     | dir | handshake   | payload
// ------------+-----+-------------+------------------------------------
// sample_in   | in  | valid/ready | raw_x, raw_y, raw_pressure
// touch_out   | out | valid/ready | touch_valid, screen_x, screen_y
// cfg         | in  | cfg_we      | cfg_index, cfg_data
//
// one sample accepted per cycle unless stalled; results leave through the result register
// stage 1 maps both axes through the gain multipliers, stage 2 qualifies and accumulates
// the jump test and accumulators loop within stage 2, one sample each cycle unless stalled
// arst_n clears pipeline valids, group counters, sums, last points; loads register defaults
// a stalled result holds only stages that would collide with it; others keep moving

module touch_sample_qualifier_top #(
	parameter int SAMPLES_PER_READ = tsq_pkg::SAMPLES_PER_READ_DEF,
	parameter int SCREEN_WIDTH     = tsq_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT    = tsq_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsq_pkg::CFG_DATA_W-1:0]  cfg_data,
	tsq_in_if.sink                          sample_in,
	tsq_out_if.source                       touch_out
);

	localparam int N       = SAMPLES_PER_READ;
	localparam int CNT_W   = $clog2(N + 1);
	localparam int CW_X    = $clog2(SCREEN_WIDTH);
	localparam int CW_Y    = $clog2(SCREEN_HEIGHT);
	localparam int JW_X    = (CW_X > tsq_pkg::JUMP_W) ? CW_X : tsq_pkg::JUMP_W;
	localparam int JW_Y    = (CW_Y > tsq_pkg::JUMP_W) ? CW_Y : tsq_pkg::JUMP_W;
	localparam int SUM_X_W = $clog2(N * SCREEN_WIDTH);
	localparam int SUM_Y_W = $clog2(N * SCREEN_HEIGHT);
	localparam int SUM_M_W = (SUM_X_W > SUM_Y_W) ? SUM_X_W : SUM_Y_W;
	// floor(sum / N) as multiply by a rounded-up reciprocal, exact over the sum range
	localparam int DIV_SHIFT = SUM_M_W + $clog2(N) + 1;
	localparam int RECIP     = ((2 ** DIV_SHIFT) + N - 1) / N;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam int PX_W      = SUM_X_W + RECIP_W;
	localparam int PY_W      = SUM_Y_W + RECIP_W;

	// configuration registers
	logic signed [tsq_pkg::GAIN_W-1:0]   gain_x_q, gain_y_q;
	logic signed [tsq_pkg::OFFSET_W-1:0] offset_x_q, offset_y_q;
	logic [tsq_pkg::PRESS_W-1:0]         min_press_q, max_press_q;
	logic [tsq_pkg::JUMP_W-1:0]          max_jump_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q    <= tsq_pkg::GAIN_X_RST;
			offset_x_q  <= tsq_pkg::OFFSET_X_RST;
			gain_y_q    <= tsq_pkg::GAIN_Y_RST;
			offset_y_q  <= tsq_pkg::OFFSET_Y_RST;
			min_press_q <= tsq_pkg::MIN_PRESS_RST;
			max_press_q <= tsq_pkg::MAX_PRESS_RST;
			max_jump_q  <= tsq_pkg::MAX_JUMP_RST;
		end else if (cfg_we) begin
			unique case (tsq_pkg::cfg_reg_t'(cfg_index))
				tsq_pkg::REG_GAIN_X:       gain_x_q    <= cfg_data[tsq_pkg::GAIN_W-1:0];
				tsq_pkg::REG_OFFSET_X:     offset_x_q  <= cfg_data[tsq_pkg::OFFSET_W-1:0];
				tsq_pkg::REG_GAIN_Y:       gain_y_q    <= cfg_data[tsq_pkg::GAIN_W-1:0];
				tsq_pkg::REG_OFFSET_Y:     offset_y_q  <= cfg_data[tsq_pkg::OFFSET_W-1:0];
				tsq_pkg::REG_MIN_PRESSURE: min_press_q <= cfg_data[tsq_pkg::PRESS_W-1:0];
				tsq_pkg::REG_MAX_PRESSURE: max_press_q <= cfg_data[tsq_pkg::PRESS_W-1:0];
				tsq_pkg::REG_MAX_JUMP:     max_jump_q  <= cfg_data[tsq_pkg::JUMP_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, out_valid_q;
	logic out_free, s2_go, s2_free, s1_go, s2_last;

	assign out_free = !out_valid_q || touch_out.ready;
	assign s2_go    = valid_s2 && (!s2_last || out_free);
	assign s2_free  = !valid_s2 || s2_go;
	assign s1_go    = valid_s1 && s2_free;
	assign sample_in.ready = !valid_s1 || s1_go;

	// stage 1: input register and axis mapping
	logic [tsq_pkg::RAW_W-1:0]   raw_x_s1, raw_y_s1;
	logic [tsq_pkg::PRESS_W-1:0] press_s1;
	logic [CW_X-1:0]             tx_map;
	logic [CW_Y-1:0]             ty_map;
	logic                        hit_map;

	// screen x comes from raw y, screen y from raw x
	tsq_map_axis #(.LIMIT(SCREEN_WIDTH), .COORD_W(CW_X)) u_map_x (
		.gain   (gain_x_q),
		.offset (offset_x_q),
		.raw    (raw_y_s1),
		.coord  (tx_map)
	);

	tsq_map_axis #(.LIMIT(SCREEN_HEIGHT), .COORD_W(CW_Y)) u_map_y (
		.gain   (gain_y_q),
		.offset (offset_y_q),
		.raw    (raw_x_s1),
		.coord  (ty_map)
	);

	assign hit_map = (press_s1 >= min_press_q) && (press_s1 <= max_press_q);

	// stage 2 registers
	logic            hit_s2;
	logic [CW_X-1:0] tx_s2;
	logic [CW_Y-1:0] ty_s2;

	always_ff @(posedge clk) begin
		if (sample_in.valid && sample_in.ready) begin
			raw_x_s1 <= sample_in.raw_x;
			raw_y_s1 <= sample_in.raw_y;
			press_s1 <= sample_in.raw_pressure;
		end
		if (s1_go) begin
			hit_s2 <= hit_map;
			tx_s2  <= tx_map;
			ty_s2  <= ty_map;
		end
	end

	// stage 2: group state
	logic [CNT_W-1:0]   slot_cnt_q, acc_cnt_q, acc_next;
	logic [SUM_X_W-1:0] sum_x_q, sum_x_next;
	logic [SUM_Y_W-1:0] sum_y_q, sum_y_next;
	logic [CW_X-1:0]    prev_x_q, dx;
	logic [CW_Y-1:0]    prev_y_q, dy;
	logic               near, take, all_ok;
	logic [PX_W-1:0]    prod_x;
	logic [PY_W-1:0]    prod_y;
	logic [CW_X-1:0]    avg_x;
	logic [CW_Y-1:0]    avg_y;

	assign dx   = (tx_s2 > prev_x_q) ? tx_s2 - prev_x_q : prev_x_q - tx_s2;
	assign dy   = (ty_s2 > prev_y_q) ? ty_s2 - prev_y_q : prev_y_q - ty_s2;
	assign near = (JW_X'(dx) <= JW_X'(max_jump_q)) && (JW_Y'(dy) <= JW_Y'(max_jump_q));
	// first accepted sample of a group skips the jump test
	assign take = hit_s2 && ((acc_cnt_q == '0) || near);

	assign acc_next   = acc_cnt_q + CNT_W'(take);
	assign sum_x_next = sum_x_q + (take ? SUM_X_W'(tx_s2) : '0);
	assign sum_y_next = sum_y_q + (take ? SUM_Y_W'(ty_s2) : '0);
	assign s2_last    = (slot_cnt_q == CNT_W'(N - 1));
	assign all_ok     = (acc_next == CNT_W'(N));

	assign prod_x = PX_W'(sum_x_next * RECIP_W'(RECIP));
	assign prod_y = PY_W'(sum_y_next * RECIP_W'(RECIP));
	assign avg_x  = prod_x[DIV_SHIFT +: CW_X];
	assign avg_y  = prod_y[DIV_SHIFT +: CW_Y];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			slot_cnt_q  <= '0;
			acc_cnt_q   <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			if (sample_in.ready) begin
				valid_s1 <= sample_in.valid;
			end
			if (s2_free) begin
				valid_s2 <= s1_go;
			end
			if (s2_go && s2_last) begin
				out_valid_q <= 1'b1;
			end else if (touch_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (s2_go) begin
				if (s2_last) begin
					slot_cnt_q <= '0;
					acc_cnt_q  <= '0;
					sum_x_q    <= '0;
					sum_y_q    <= '0;
					prev_x_q   <= '0;
					prev_y_q   <= '0;
				end else begin
					slot_cnt_q <= slot_cnt_q + CNT_W'(1);
					acc_cnt_q  <= acc_next;
					sum_x_q    <= sum_x_next;
					sum_y_q    <= sum_y_next;
					if (take) begin
						prev_x_q <= tx_s2;
						prev_y_q <= ty_s2;
					end
				end
			end
		end
	end

	// result register
	logic                           touch_valid_q;
	logic [tsq_pkg::SCREEN_X_W-1:0] screen_x_q;
	logic [tsq_pkg::SCREEN_Y_W-1:0] screen_y_q;

	always_ff @(posedge clk) begin
		if (s2_go && s2_last) begin
			touch_valid_q <= all_ok;
			screen_x_q    <= all_ok ? tsq_pkg::SCREEN_X_W'(avg_x) : '0;
			screen_y_q    <= all_ok ? tsq_pkg::SCREEN_Y_W'(avg_y) : '0;
		end
	end

	assign touch_out.valid       = out_valid_q;
	assign touch_out.touch_valid = touch_valid_q;
	assign touch_out.screen_x    = screen_x_q;
	assign touch_out.screen_y    = screen_y_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !touch_valid_q |-> (screen_x_q == '0) && (screen_y_q == '0))
		else $error("invalid touch result carries non-zero coordinates");

	a_acc_le_slot: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cnt_q <= slot_cnt_q)
		else $error("more accepted samples than slots used");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_cnt_q < CNT_W'(N))
		else $error("slot count past group size");

	a_group_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go && s2_last |=> (slot_cnt_q == '0) && (acc_cnt_q == '0) && out_valid_q)
		else $error("group state not cleared after result");

	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in.valid && sample_in.ready && valid_s1 |-> s1_go)
		else $error("stage 1 overwritten while holding an item");

endmodule
